// ===== src/palindromic_substring_counter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// palindromic substring counter - assertion macros
// shared property wrappers for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef PALINDROMIC_SUBSTRING_COUNTER_UNIT_DEFINES_SVH
`define PALINDROMIC_SUBSTRING_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define PSCU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pscu check failed");

// next-cycle implication, off while in reset
`define PSCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pscu check failed");

`endif

// ===== src/pscu_pkg.sv =====
// ----------------------------------------------------------------------------
// pscu_pkg
// sizes and controller/datapath command and status types
// ----------------------------------------------------------------------------
package pscu_pkg;

    // character store depth and derived widths
    localparam int MAX_LEN  = 256;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int IDX_W    = ADDR_W + 1;
    localparam int WIDE_W   = IDX_W + 1;
    localparam int CTR_W    = $clog2(2 * MAX_LEN);
    localparam int CMP_W    = CTR_W + 1;
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // controller to datapath
    typedef struct packed {
        logic load;     // store the incoming byte
        logic start;    // latch length, clear center and total
        logic setup;    // place lo/hi at the current center
        logic read;     // read both characters
        logic advance;  // count a match, widen the span
        logic next;     // move to the next center
        logic publish;  // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_last;
        logic centers_done;
        logic in_range;
        logic chars_equal;
        logic out_full;
    } t_sts;

endpackage

// ===== src/pscu_in_if.sv =====
// ----------------------------------------------------------------------------
// pscu_in_if
// input channel: one string byte per item
// ----------------------------------------------------------------------------
interface pscu_in_if;
    logic                               valid;
    logic                               ready;
    logic [pscu_pkg::CHAR_W-1:0]        char_code;
    logic                               last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== src/pscu_out_if.sv =====
// ----------------------------------------------------------------------------
// pscu_out_if
// output channel: one count item per string
// ----------------------------------------------------------------------------
interface pscu_out_if;
    logic                               valid;
    logic                               ready;
    logic [pscu_pkg::COUNT_W-1:0]       palindrome_count;
    logic                               overflow_flag;

    modport source (output valid, output palindrome_count, output overflow_flag,
                    input ready);
    modport sink   (input valid, input palindrome_count, input overflow_flag,
                    output ready);
endinterface

// ===== src/pscu_ctrl.sv =====
// ----------------------------------------------------------------------------
// pscu_ctrl
// sequencer: loads bytes, then walks every center and widens spans
// ----------------------------------------------------------------------------
module pscu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pscu_pkg::t_sts      i_sts,
    output pscu_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_LOAD    = 5'b00001,
        S_SETUP   = 5'b00010,
        S_READ    = 5'b00100,
        S_CMP     = 5'b01000,
        S_PUBLISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_LOAD);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_last) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                if (i_sts.centers_done) begin
                    n_state = S_PUBLISH;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.in_range) begin
                    o_cmd.read = 1'b1;
                    n_state    = S_CMP;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_CMP: begin
                if (i_sts.chars_equal) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_PUBLISH: begin
                if (!i_sts.out_full) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// ===== src/pscu_dp.sv =====
// ----------------------------------------------------------------------------
// pscu_dp
// datapath: character memory, span pointers, counter and output register
// ----------------------------------------------------------------------------
module pscu_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [pscu_pkg::CHAR_W-1:0]         i_char_code,
    input  logic                                i_last_char,
    input  logic                                i_out_ready,
    input  pscu_pkg::t_cmd                      i_cmd,
    output pscu_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    output logic [pscu_pkg::COUNT_W-1:0]        o_palindrome_count,
    output logic                                o_overflow_flag
);

    logic [pscu_pkg::CHAR_W-1:0]    r_mem [pscu_pkg::MAX_LEN];
    logic [pscu_pkg::LEN_W-1:0]     r_len;
    logic                           r_drop;
    logic [pscu_pkg::LEN_W-1:0]     r_n;
    logic                           r_flag;
    logic [pscu_pkg::CTR_W-1:0]     r_ctr;
    logic [pscu_pkg::IDX_W-1:0]     r_lo;
    logic [pscu_pkg::IDX_W-1:0]     r_hi;
    logic [pscu_pkg::CHAR_W-1:0]    r_ch_lo;
    logic [pscu_pkg::CHAR_W-1:0]    r_ch_hi;
    logic [pscu_pkg::COUNT_W-1:0]   r_total;
    logic                           r_out_valid;
    logic [pscu_pkg::COUNT_W-1:0]   r_out_count;
    logic                           r_out_flag;

    logic                           w_has_room;
    logic [pscu_pkg::LEN_W-1:0]     w_len_after;
    logic [pscu_pkg::IDX_W-1:0]     w_half;

    assign w_has_room  = (r_len < pscu_pkg::LEN_W'(pscu_pkg::MAX_LEN));
    assign w_len_after = w_has_room ? (r_len + pscu_pkg::LEN_W'(1)) : r_len;
    assign w_half      = pscu_pkg::IDX_W'(r_ctr >> 1);

    // character memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_has_room) begin
            r_mem[r_len[pscu_pkg::ADDR_W-1:0]] <= i_char_code;
        end
        if (i_cmd.read) begin
            r_ch_lo <= r_mem[r_lo[pscu_pkg::ADDR_W-1:0]];
            r_ch_hi <= r_mem[r_hi[pscu_pkg::ADDR_W-1:0]];
        end
    end

    // load length and drop tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.start) begin
            r_len  <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.load) begin
            r_len  <= w_len_after;
            r_drop <= r_drop | ~w_has_room;
        end
    end

    // center walk and span pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n     <= w_len_after;
            r_flag  <= r_drop | ~w_has_room;
            r_ctr   <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.next) begin
                r_ctr <= r_ctr + pscu_pkg::CTR_W'(1);
            end
            if (i_cmd.advance && (r_total != pscu_pkg::COUNT_MAX)) begin
                r_total <= r_total + pscu_pkg::COUNT_W'(1);
            end
        end
        if (i_cmd.setup) begin
            r_lo <= w_half;
            r_hi <= w_half + pscu_pkg::IDX_W'(r_ctr[0]);
        end else if (i_cmd.advance) begin
            r_lo <= r_lo - pscu_pkg::IDX_W'(1);
            r_hi <= r_hi + pscu_pkg::IDX_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_count <= r_total;
            r_out_flag  <= r_flag;
        end
    end

    // status back to the sequencer
    assign o_sts.in_last      = i_last_char;
    assign o_sts.centers_done = (pscu_pkg::CMP_W'(r_ctr) + pscu_pkg::CMP_W'(1))
                                >= pscu_pkg::CMP_W'({r_n, 1'b0});
    assign o_sts.in_range     = !r_lo[pscu_pkg::IDX_W-1]
                                && (pscu_pkg::WIDE_W'(r_hi) < pscu_pkg::WIDE_W'(r_n));
    assign o_sts.chars_equal  = (r_ch_lo == r_ch_hi);
    assign o_sts.out_full     = r_out_valid & ~i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_palindrome_count = r_out_count;
    assign o_overflow_flag    = r_out_flag;

endmodule

// ===== src/palindromic_substring_counter_unit.sv =====
// ----------------------------------------------------------------------------
// palindromic_substring_counter_unit
// counts palindromic substrings of a byte string loaded one item at a time
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle into a 256-entry character memory; bytes past
// that depth are dropped and the result carries overflow_flag. The item with
// last_char starts the count and the input stays not ready until the result
// is placed in the output register, which may wait for the sink while the
// next string loads. The count walks all 2n-1 centers of an n-byte string:
// each center passes SETUP, then READ and CMP for every matching
// character pair, until a mismatch in CMP or the string edge in READ
// moves on. The pace is set by the registered two-port read of the
// character memory: each compare follows its read in a separate state.
`include "palindromic_substring_counter_unit_defines.svh"

module palindromic_substring_counter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pscu_in_if.sink     i_in,
    pscu_out_if.source  o_out
);

    pscu_pkg::t_cmd w_cmd;
    pscu_pkg::t_sts w_sts;

    // sequencer
    pscu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    pscu_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_char_code        (i_in.char_code),
        .i_last_char        (i_in.last_char),
        .i_out_ready        (o_out.ready),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .o_out_valid        (o_out.valid),
        .o_palindrome_count (o_out.palindrome_count),
        .o_overflow_flag    (o_out.overflow_flag)
    );

    // checks
    `PSCU_ASSERT_SAME(a_read_in_range, i_clk, i_rst_n, w_cmd.read, w_sts.in_range)
    `PSCU_ASSERT_SAME(a_publish_free, i_clk, i_rst_n, w_cmd.publish, !w_sts.out_full)
    `PSCU_ASSERT_NEXT(a_read_then_cmp, i_clk, i_rst_n, w_cmd.read, !i_in.ready && !w_cmd.read)

endmodule

// ===== tb/sv/palindromic_substring_counter_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palindromic_substring_counter_unit_test
// Sends byte strings to the counter and compares each count item with a
// locally computed center-expansion count. Short directed strings come
// first. Random strings follow: near-palindromes, small-alphabet text, noise
// and runs of one byte, with one full-depth string and one that overflows
// the store. Both channels idle at random, with one stretch that never idles.
// ----------------------------------------------------------------------------
module palindromic_substring_counter_unit_test;

    localparam int ITEM_TARGET = 1700;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 32;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [pscu_pkg::COUNT_W-1:0] count;
        logic                         overflow;
    } t_count_item;

    // mirrors the character store and produces the expected count items
    class palindrome_tally;
        logic [pscu_pkg::CHAR_W-1:0] text [pscu_pkg::MAX_LEN];
        int                          text_len;
        bit                          dropped;
        t_count_item                 expected_counts [$];
        int                          failures;

        function new();
            text_len = 0;
            dropped  = 1'b0;
            failures = 0;
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        // expand around every center and count the matching spans
        function int unsigned count_palindromes();
            int unsigned total;
            int          c;
            int          lo;
            int          hi;
            total = 0;
            for (c = 0; c < 2 * text_len - 1; c++) begin
                lo = c / 2;
                hi = lo + (c % 2);
                while (lo >= 0 && hi < text_len && text[lo] == text[hi]) begin
                    total++;
                    lo--;
                    hi++;
                end
            end
            return total;
        endfunction

        // store or drop an accepted byte, close the string on the last one
        function void note_char(logic [pscu_pkg::CHAR_W-1:0] code, logic last);
            int unsigned total;
            t_count_item want;
            if (text_len < pscu_pkg::MAX_LEN) begin
                text[text_len] = code;
                text_len++;
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                total = count_palindromes();
                if (total > pscu_pkg::COUNT_MAX) begin
                    total = 32'(pscu_pkg::COUNT_MAX);
                end
                want.count    = total[pscu_pkg::COUNT_W-1:0];
                want.overflow = dropped;
                expected_counts.push_back(want);
                text_len = 0;
                dropped  = 1'b0;
            end
        endfunction

        function void check_count(logic [pscu_pkg::COUNT_W-1:0] count, logic overflow);
            t_count_item want;
            if (expected_counts.size() == 0) begin
                report($sformatf("unexpected count item %0d overflow %0b", count, overflow));
                return;
            end
            want = expected_counts.pop_front();
            if (count !== want.count) begin
                report($sformatf("palindrome_count expected %0d got %0d", want.count, count));
            end
            if (overflow !== want.overflow) begin
                report($sformatf("overflow_flag expected %0b got %0b", want.overflow,
                                 overflow));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pscu_in_if  in_if ();
    pscu_out_if out_if ();

    palindromic_substring_counter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    palindrome_tally             tally = new();
    logic [pscu_pkg::CHAR_W-1:0] text_q [$];
    int                          items_sent;
    int                          cycle_count;
    bit                          no_idle;

    // clock, 12 ns period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side stalls at random
    always @(posedge i_clk) begin
        out_if.ready <= i_rst_n && (no_idle || $urandom_range(0, 99) >= 35);
    end

    // accepted input items feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            tally.note_char(in_if.char_code, in_if.last_char);
        end
    end

    // accepted count items are checked
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            tally.check_count(out_if.palindrome_count, out_if.overflow_flag);
        end
    end

    // send text_q, last_char on its final byte, with random gaps
    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++) begin
            while (!no_idle && $urandom_range(0, 99) < 35) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_if.valid     <= 1'b1;
            in_if.char_code <= text_q[i];
            in_if.last_char <= (i == text_q.size() - 1);
            @(posedge i_clk);
            while (!in_if.ready) begin
                @(posedge i_clk);
            end
            items_sent++;
        end
    endtask

    // random string: noise, small alphabet, near-palindrome or one repeated byte
    task automatic fill_random_text();
        logic [pscu_pkg::CHAR_W-1:0] letters [3];
        int                          len;
        int                          kind;
        int                          i;
        int                          half;
        letters[0] = pscu_pkg::CHAR_W'($urandom_range(0, 255));
        letters[1] = pscu_pkg::CHAR_W'($urandom_range(0, 255));
        letters[2] = pscu_pkg::CHAR_W'($urandom_range(0, 255));
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        kind = $urandom_range(0, 3);
        half = (len + 1) / 2;
        text_q.delete();
        for (i = 0; i < len; i++) begin
            case (kind)
                0: begin
                    text_q.push_back(pscu_pkg::CHAR_W'($urandom_range(0, 255)));
                end
                1: begin
                    text_q.push_back(letters[$urandom_range(0, 1)]);
                end
                2: begin
                    if (i < half) begin
                        text_q.push_back(letters[$urandom_range(0, 2)]);
                    end else begin
                        text_q.push_back(text_q[len - 1 - i]);
                    end
                end
                default: begin
                    text_q.push_back(letters[0]);
                end
            endcase
        end
        // break the symmetry now and then
        if (kind == 2 && $urandom_range(0, 2) == 0) begin
            text_q[$urandom_range(0, len - 1)] = pscu_pkg::CHAR_W'($urandom_range(0, 255));
        end
    endtask

    initial begin
        int  i;
        bit  long_done;
        bit  drained;
        logic [pscu_pkg::CHAR_W-1:0] fill;
        long_done        = 1'b0;
        drained          = 1'b0;
        no_idle          = 1'b0;
        items_sent       = 0;
        cycle_count      = 0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.char_code  = '0;
        in_if.last_char  = 1'b0;
        out_if.ready     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single bytes at the extremes, pairs, odd and even palindromes
        text_q = {8'h00};
        send_text();
        text_q = {8'hFF};
        send_text();
        text_q = {8'h00, 8'h00};
        send_text();
        text_q = {8'hFF, 8'h00};
        send_text();
        text_q = {8'h80, 8'h7F, 8'h80};
        send_text();
        text_q = {8'h55, 8'hAA, 8'hAA, 8'h55};
        send_text();
        text_q = {8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        send_text();
        text_q = {8'h61, 8'h61, 8'h61};
        send_text();

        // random strings
        while (items_sent < ITEM_TARGET) begin
            if (!long_done && items_sent >= 400) begin
                // full store of one byte gives the largest count
                fill = pscu_pkg::CHAR_W'($urandom_range(0, 255));
                text_q.delete();
                for (i = 0; i < pscu_pkg::MAX_LEN; i++) begin
                    text_q.push_back(fill);
                end
                send_text();
                // one byte too many, dropped even though it carries last_char
                text_q.delete();
                for (i = 0; i <= pscu_pkg::MAX_LEN; i++) begin
                    text_q.push_back($urandom_range(0, 1) ? 8'h3C : 8'hC3);
                end
                send_text();
                long_done = 1'b1;
            end
            if (!drained && items_sent >= 1000) begin
                // hold off until every count item is back
                in_if.valid <= 1'b0;
                @(posedge i_clk);
                while (tally.expected_counts.size() != 0) begin
                    @(posedge i_clk);
                end
                drained = 1'b1;
            end
            no_idle = (items_sent >= 1150 && items_sent < 1400);
            fill_random_text();
            send_text();
        end
        no_idle = 1'b0;
        in_if.valid <= 1'b0;
        @(posedge i_clk);

        // wait for the outstanding count items, then let the block settle
        while (tally.expected_counts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tally.expected_counts.size() != 0) begin
            $display("%0d count items never arrived", tally.expected_counts.size());
            tally.failures++;
        end

        if (tally.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/pscu_pkg.sv
src/pscu_in_if.sv
src/pscu_out_if.sv
src/pscu_ctrl.sv
src/pscu_dp.sv
src/palindromic_substring_counter_unit.sv
tb/sv/palindromic_substring_counter_unit_test.sv
